[sv/sha_pkg.sv]
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

endpackage

[sv/sha_round.sv]
module sha_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [511:0]           block_i,
  input  logic [7:0][31:0]       chain_i,
  output logic [7:0][31:0]       vars_o,
  output sha_pkg::rnd_sts_t      sts_o
);
  import sha_pkg::*;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [5:0] LAST_ROUND = 6'd63;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [15:0][31:0] win_q, win_d;
  logic [7:0][31:0]  var_q, var_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [31:0] w_new, t1, t2, s0, s1, bs0, bs1, ch, maj;

  always_comb begin
    s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = s1 + win_q[9] + s0 + win_q[0];
    bs1   = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
    ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    bs0   = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
    maj   = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1    = var_q[7] + bs1 + ch + K_TABLE[cnt_q] + win_q[0];
    t2    = bs0 + maj;
  end

  always_comb begin
    win_d  = win_q;
    var_d  = var_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      for (int i = 0; i < 16; i++) begin
        win_d[i] = block_i[511 - 32 * i -: 32];
      end
      var_d  = chain_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[15] = w_new;
      var_d[7]  = var_q[6];
      var_d[6]  = var_q[5];
      var_d[5]  = var_q[4];
      var_d[4]  = var_q[3] + t1;
      var_d[3]  = var_q[2];
      var_d[2]  = var_q[1];
      var_d[1]  = var_q[0];
      var_d[0]  = t1 + t2;
      cnt_d     = cnt_q + 6'd1;
      if (cnt_q == LAST_ROUND) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    var_q <= var_d;
  end

  assign vars_o     = var_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[sv/sha256_stream_hasher_top.sv]
// a data beat is taken while idle; the 64th byte of a block starts a compression
// (load, 64 rounds of the shared round unit, chaining add), with input stalled meanwhile
// end of message: one pad byte per cycle up to the next block end, one or two compressions,
// then eight digest beats; no new byte is taken until the last digest beat is accepted
// reset: asynchronous active low, chaining state back to the initial hash, counters cleared
module sha256_stream_hasher_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sha_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sha_pkg::out_t  out_data_o
);
  import sha_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [2:0] IDX_LAST  = 3'd7;

  localparam logic [7:0][31:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  logic [1:0]       state_q, state_d;
  logic [511:0]     block_q, block_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      bits_q, bits_d;
  logic [7:0][31:0] chain_q, chain_d;
  logic [2:0]       idx_q, idx_d;
  logic             end_q, end_d;
  logic             p80_q, p80_d;
  logic             two_q, two_d;
  logic             final_q, final_d;
  logic             start_q, start_d;

  logic             shift_en;
  logic [7:0]       shift_byte;
  logic [63:0]      len_sh;
  logic             len_byte;
  logic [7:0][31:0] vars;
  rnd_sts_t         rnd_sts;

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .block_i (block_q),
    .chain_i (chain_q),
    .vars_o  (vars),
    .sts_o   (rnd_sts)
  );

  assign len_sh   = bits_q >> {~fill_q[2:0], 3'b000};
  assign len_byte = p80_q && (fill_q >= LEN_START) && !two_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    chain_d    = chain_q;
    idx_d      = idx_q;
    end_d      = end_q;
    p80_d      = p80_q;
    two_d      = two_q;
    final_d    = final_q;
    start_d    = 1'b0;
    shift_en   = 1'b0;
    shift_byte = in_data_i.msg_byte;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          end_d = in_data_i.end_of_message;
          p80_d = 1'b0;
          two_d = 1'b0;
          if (in_data_i.byte_valid) begin
            shift_en = 1'b1;
            bits_d   = bits_q + 64'd8;
          end
          if (in_data_i.byte_valid && fill_q == FILL_LAST) begin
            start_d = 1'b1;
            final_d = 1'b0;
            state_d = ST_COMP;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (!p80_q) begin
          shift_byte = PAD_BYTE;
        end else if (len_byte) begin
          shift_byte = len_sh[7:0];
        end else begin
          shift_byte = '0;
        end
        p80_d = 1'b1;
        two_d = two_q || (!p80_q && fill_q >= LEN_START);
        if (fill_q == FILL_LAST) begin
          start_d = 1'b1;
          final_d = len_byte;
          two_d   = 1'b0;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_sts.done) begin
          for (int i = 0; i < 8; i++) begin
            chain_d[i] = chain_q[i] + vars[i];
          end
          if (final_q) begin
            idx_d   = '0;
            state_d = ST_OUT;
          end else if (end_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == IDX_LAST) begin
            chain_d = IV;
            bits_d  = '0;
            end_d   = 1'b0;
            final_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    block_d = block_q;
    if (shift_en) begin
      block_d = {block_q[503:0], shift_byte};
      fill_d  = fill_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      chain_q <= IV;
      idx_q   <= '0;
      end_q   <= 1'b0;
      p80_q   <= 1'b0;
      two_q   <= 1'b0;
      final_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      chain_q <= chain_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      p80_q   <= p80_d;
      two_q   <= two_d;
      final_q <= final_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
  end

  assign in_stall_o             = (state_q != ST_IDLE);
  assign out_valid_o            = (state_q == ST_OUT);
  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == IDX_LAST);

  a_round_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_sts.busy || rnd_sts.done || start_q) |-> state_q == ST_COMP)
    else $error("round unit active outside compression");

  a_start_loads_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> fill_q == '0)
    else $error("compression started on a partial block");

  a_last_beat_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_word) |=>
      (state_q == ST_IDLE && fill_q == '0 && bits_q == '0 && chain_q == IV))
    else $error("message state not reinitialized after digest");

  a_pad_len_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && two_q) |-> p80_q)
    else $error("second pad block flagged before the pad byte");

endmodule

[tb/sha256_digest_monitor.sv]
`timescale 1ns / 1ps

module sha256_digest_monitor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  sha_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  sha_pkg::out_t out_data_i,
  output int            mismatches_o,
  output int            words_waiting_o,
  output int            words_checked_o
);

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [64*32-1:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]   hash_state [8];
  logic [7:0]    block_bytes [64];
  int            block_fill;
  logic [63:0]   bit_count;
  sha_pkg::out_t digest_q [$];
  sha_pkg::out_t expected_word;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void start_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[(7 - i) * 32 +: 32];
    block_fill = 0;
    bit_count = '0;
  endfunction

  function automatic void compress_block_bytes();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        s0 = ror(w[(r - 15) % 16], 7) ^ ror(w[(r - 15) % 16], 18) ^ (w[(r - 15) % 16] >> 3);
        s1 = ror(w[(r - 2) % 16], 17) ^ ror(w[(r - 2) % 16], 19) ^ (w[(r - 2) % 16] >> 10);
        w[r % 16] = s1 + w[(r - 7) % 16] + s0 + w[r % 16];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[(63 - r) * 32 +: 32] + w[r % 16];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void absorb_item(input sha_pkg::in_t item);
    int k;
    sha_pkg::out_t word;
    if (item.byte_valid) begin
      block_bytes[block_fill] = item.msg_byte;
      block_fill++;
      bit_count = bit_count + 64'd8;
      if (block_fill == 64) begin
        compress_block_bytes();
        block_fill = 0;
      end
    end
    if (item.end_of_message) begin
      k = block_fill;
      block_bytes[k] = 8'h80;
      k++;
      // length field no longer fits, spill into a second block
      if (k > 56) begin
        while (k < 64) begin
          block_bytes[k] = 8'h00;
          k++;
        end
        compress_block_bytes();
        k = 0;
      end
      while (k < 56) begin
        block_bytes[k] = 8'h00;
        k++;
      end
      for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_count[(7 - i) * 8 +: 8];
      compress_block_bytes();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = hash_state[i];
        word.word_index = 3'(i);
        word.last_word = (i == 7);
        digest_q.push_back(word);
      end
      start_digest();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_digest();
      digest_q.delete();
      mismatches_o = 0;
      words_waiting_o = 0;
      words_checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) absorb_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest beat with none expected: actual %h", $time, out_data_i);
          mismatches_o++;
        end else begin
          expected_word = digest_q.pop_front();
          if (out_data_i.digest_word !== expected_word.digest_word ||
              out_data_i.word_index !== expected_word.word_index ||
              out_data_i.last_word !== expected_word.last_word) begin
            $display("%0t: digest beat wrong: expected %h/%0d/%b, actual %h/%0d/%b",
                     $time, expected_word.digest_word, expected_word.word_index,
                     expected_word.last_word, out_data_i.digest_word, out_data_i.word_index,
                     out_data_i.last_word);
            mismatches_o++;
          end
          words_checked_o++;
        end
      end
      words_waiting_o = digest_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int ITEM_TARGET  = 350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  sha_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sha_pkg::out_t out_data;

  int mismatches, words_waiting, words_checked;
  int cycle_count = 0;
  int send_gap_pct = 13;
  int stall_pct = 65;
  int items_sent = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int two_block_pads = 0;
  int msg_len = 0;
  int pad_edge_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  always #1 clk = ~clk;

  sha256_stream_hasher_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sha256_digest_monitor u_digest_mon (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatches_o    (mismatches),
    .words_waiting_o (words_waiting),
    .words_checked_o (words_checked)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words still waiting",
               cycle_count, words_waiting);
      $display("sha256_stream_hasher_top: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
    sha_pkg::in_t item;
    item.msg_byte = b;
    item.byte_valid = bv;
    item.end_of_message = eom;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (bv) begin
      bytes_sent++;
      msg_len++;
    end
    if (eom) begin
      messages_sent++;
      if (msg_len % 64 >= 56) two_block_pads++;
      msg_len = 0;
    end
  endtask

  initial begin
    int len;
    int pick;
    bit tail_on_eom;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty message, single byte on the closing beat, gap beats, "abc", another empty message
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      send_gap_pct = (items_sent < 120) ? 13 : (items_sent < 240) ? 65 : 0;
      stall_pct    = (items_sent < 120) ? 65 : (items_sent < 240) ? 13 : 0;
      pick = $urandom_range(99);
      if (pick < 55) len = $urandom_range(15);
      else if (pick < 85) len = pad_edge_len[$urandom_range(7)];
      else len = $urandom_range(130);
      tail_on_eom = 1'($urandom_range(1));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(7) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        send_item(8'($urandom_range(255)), 1'b1, tail_on_eom && (k == len - 1));
      end
      if (len == 0 || !tail_on_eom) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("hashed %0d messages, %0d bytes over %0d beats; %0d needed a second pad block",
             messages_sent, bytes_sent, items_sent, two_block_pads);
    $display("checked %0d digest words under three sender/receiver stall mixes",
             words_checked);
    if (mismatches == 0) begin
      $display("sha256_stream_hasher_top: match");
    end else begin
      $display("sha256_stream_hasher_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sha_pkg.sv
sv/sha_round.sv
sv/sha256_stream_hasher_top.sv
tb/sha256_digest_monitor.sv
tb/tb.sv
